@@ src/hvn_pkg.sv @@
// Shared types, constants and helpers for the hashed value-noise generator.
`default_nettype none
package hvn_pkg;

  localparam int NUM_OCT  = 7;
  localparam int SW       = 34;
  localparam int DIM_W    = 11;
  localparam int HW       = 64;
  localparam int DIV9_MUL = 7282;
  localparam int DIV9_SH  = 16;

  typedef logic signed [SW-1:0] coord_t;
  typedef logic [DIM_W-1:0]     dim_t;
  typedef logic [6:0]           side_t;

  localparam logic       CMD_GEN    = 1'b0;
  localparam logic       CMD_READ   = 1'b1;
  localparam logic [1:0] ST_DONE    = 2'd0;
  localparam logic [1:0] ST_VALID   = 2'd1;
  localparam logic [1:0] ST_REFUSED = 2'd2;

  typedef enum logic [1:0] {
    REG_ORIGIN_X = 2'd0,
    REG_ORIGIN_Y = 2'd1,
    REG_WIDTH    = 2'd2,
    REG_HEIGHT   = 2'd3
  } reg_idx_t;

  typedef struct packed {
    logic gen_go;
    logic rd_go;
  } eng_req_t;

  typedef struct packed {
    logic       done;
    logic       is_gen;
    logic [7:0] pixel;
  } eng_rsp_t;

  // C-style truncating halve
  function automatic coord_t half_trunc(coord_t v);
    return (v >>> 1) + coord_t'(v[SW-1] & v[0]);
  endfunction

  function automatic coord_t lo_shrink(coord_t v);
    return half_trunc(v) - coord_t'(1);
  endfunction

  function automatic coord_t hi_shrink(coord_t v);
    return coord_t'(1) - half_trunc(-v);
  endfunction

endpackage
`default_nettype wire

@@ src/hvn_hash.sv @@
// Iterative 64-bit cell hash: one shift/add/xor step per cycle.
`default_nettype none
module hvn_hash (
  input  wire logic                  clk,
  input  wire logic                  rst_n,
  input  wire logic                  go,
  input  wire logic [hvn_pkg::HW-1:0] px,
  input  wire logic [hvn_pkg::HW-1:0] py,
  input  wire logic [2:0]            oct,
  output logic                       done,
  output logic [hvn_pkg::HW-1:0]     hash_val
);
  import hvn_pkg::*;

  typedef enum logic [1:0] {
    H_IDLE = 2'b01,
    H_RUN  = 2'b10
  } hstate_t;

  typedef enum logic [1:0] {
    OP_ADDV, OP_XSHL, OP_XVSHL, OP_ASAR
  } hop_kind_t;

  typedef struct packed {
    hop_kind_t  kind;
    logic [5:0] sh;
    logic       last;
  } hop_t;

  hstate_t       state_r;
  logic          done_r;
  logic [HW-1:0] a_r, v_r, py_r;
  logic [2:0]    oct_r;
  logic [1:0]    c_r, word_r;
  logic [3:0]    p_r;
  hop_t          op;
  logic [HW-1:0] b, res, wnext;

  function automatic hop_t mk(hop_kind_t k, logic [5:0] s, logic l);
    hop_t o;
    o.kind = k;
    o.sh   = s;
    o.last = l;
    return o;
  endfunction

  function automatic hop_t common_op(logic [2:0] i);
    hop_t o;
    case (i)
      3'd0:    o = mk(OP_XSHL, 6'd6, 1'b0);
      3'd1:    o = mk(OP_ASAR, 6'd10, 1'b0);
      3'd2:    o = mk(OP_XSHL, 6'd8, 1'b0);
      3'd3:    o = mk(OP_ASAR, 6'd34, 1'b0);
      3'd4:    o = mk(OP_XSHL, 6'd50, 1'b0);
      default: o = mk(OP_ASAR, 6'd12, 1'b1);
    endcase
    return o;
  endfunction

  function automatic hop_t get_op(logic [1:0] c, logic [3:0] p);
    hop_t o;
    case (c)
      2'd3: begin
        case (p)
          4'd0:    o = mk(OP_ADDV, 6'd0, 1'b0);
          4'd1:    o = mk(OP_XSHL, 6'd32, 1'b0);
          4'd2:    o = mk(OP_XVSHL, 6'd36, 1'b0);
          4'd3:    o = mk(OP_ASAR, 6'd22, 1'b0);
          default: o = common_op(3'(p - 4'd4));
        endcase
      end
      2'd2: begin
        case (p)
          4'd0:    o = mk(OP_ADDV, 6'd0, 1'b0);
          4'd1:    o = mk(OP_XSHL, 6'd22, 1'b0);
          4'd2:    o = mk(OP_ASAR, 6'd34, 1'b0);
          default: o = common_op(3'(p - 4'd3));
        endcase
      end
      2'd1: begin
        case (p)
          4'd0:    o = mk(OP_ADDV, 6'd0, 1'b0);
          4'd1:    o = mk(OP_XSHL, 6'd20, 1'b0);
          4'd2:    o = mk(OP_ASAR, 6'd2, 1'b0);
          default: o = common_op(3'(p - 4'd3));
        endcase
      end
      default: o = common_op(p[2:0]);
    endcase
    return o;
  endfunction

  always_comb begin
    op = get_op(c_r, p_r);
    case (op.kind)
      OP_ADDV:  b = v_r;
      OP_XSHL:  b = a_r << op.sh;
      OP_XVSHL: b = v_r << op.sh;
      default:  b = HW'($signed(a_r) >>> op.sh);
    endcase
    res   = (op.kind == OP_XSHL || op.kind == OP_XVSHL) ? (a_r ^ b) : (a_r + b);
    wnext = res ^ ((word_r == 2'd0) ? py_r : HW'(oct_r));
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= H_IDLE;
      done_r  <= 1'b0;
    end else begin
      done_r <= 1'b0;
      unique case (state_r)
        H_IDLE: begin
          if (go) begin
            a_r     <= px;
            v_r     <= px;
            c_r     <= px[1:0];
            p_r     <= '0;
            word_r  <= '0;
            py_r    <= py;
            oct_r   <= oct;
            state_r <= H_RUN;
          end
        end
        H_RUN: begin
          if (op.last) begin
            if (word_r == 2'd2) begin
              a_r     <= res;
              done_r  <= 1'b1;
              state_r <= H_IDLE;
            end else begin
              a_r    <= wnext;
              v_r    <= wnext;
              c_r    <= wnext[1:0];
              p_r    <= '0;
              word_r <= word_r + 2'd1;
            end
          end else begin
            a_r <= res;
            p_r <= p_r + 4'd1;
          end
        end
        default: state_r <= H_IDLE;
      endcase
    end
  end

  assign done     = done_r;
  assign hash_val = a_r;

endmodule
`default_nettype wire

@@ src/hvn_engine.sv @@
// Octave sequencer with the two field memories: hash, blur, trim and pixel reads.
`default_nettype none
module hvn_engine #(
  parameter int FIELD_SIDE = 128
) (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire hvn_pkg::eng_req_t req,
  input  wire logic signed [30:0] origin_x,
  input  wire logic signed [30:0] origin_y,
  input  wire hvn_pkg::side_t    side_w,
  input  wire hvn_pkg::side_t    side_h,
  input  wire logic [5:0]        rd_col,
  input  wire logic [5:0]        rd_row,
  output hvn_pkg::eng_rsp_t      rsp
);
  import hvn_pkg::*;

  localparam int DEPTH  = FIELD_SIDE * FIELD_SIDE;
  localparam int ADDR_W = $clog2(DEPTH);

  typedef enum logic [13:0] {
    S_IDLE  = 14'h0001,
    S_OCT   = 14'h0002,
    S_GEOM  = 14'h0004,
    S_SETUP = 14'h0008,
    S_HRD   = 14'h0010,
    S_HWAIT = 14'h0020,
    S_BTAP  = 14'h0040,
    S_BLAST = 14'h0080,
    S_BDIV  = 14'h0100,
    S_BWR   = 14'h0200,
    S_TRD   = 14'h0400,
    S_TWR   = 14'h0800,
    S_PRD   = 14'h1000,
    S_POUT  = 14'h2000
  } estate_t;

  logic [7:0] front_mem [DEPTH];
  logic [7:0] back_mem  [DEPTH];

  estate_t    state_r, state_nxt;
  logic [2:0] oct_r, oct_nxt, cnt_r, cnt_nxt;
  coord_t     nx_r, nx_nxt, ny_r, ny_nxt, nxh_r, nxh_nxt, nyh_r, nyh_nxt;
  coord_t     cx_r, cx_nxt, cy_r, cy_nxt;
  dim_t       cw_r, cw_nxt, ch_r, ch_nxt, nw_r, nw_nxt, nh_r, nh_nxt;
  dim_t       bw_r, bw_nxt, bh_r, bh_nxt;
  logic [1:0] xoff_r, xoff_nxt, yoff_r, yoff_nxt;
  dim_t       j_r, j_nxt, k_r, k_nxt;
  logic [1:0] dx_r, dx_nxt, dy_r, dy_nxt;
  logic [11:0] acc_r, acc_nxt;
  logic [7:0] q_r, q_nxt;
  logic       tok_r, tok_nxt;

  logic              fr_re, fw_we, br_re, bw_we;
  logic [ADDR_W-1:0] fr_addr, fw_addr, br_addr, bw_addr;
  logic [7:0]        fw_data, bw_data, fr_q_r, br_q_r;

  logic          hgo, hdone;
  logic [HW-1:0] hpx, hpy, hval;

  dim_t        tc, tr, ncw, nch;
  logic        tin;
  logic [7:0]  hbit, base;
  logic [24:0] prod;
  coord_t      x0, y0;

  function automatic logic in_fs(dim_t c, dim_t r);
    return (32'(c) < FIELD_SIDE) && (32'(r) < FIELD_SIDE);
  endfunction

  function automatic logic [ADDR_W-1:0] addr_of(dim_t c, dim_t r);
    return ADDR_W'(32'(r) * FIELD_SIDE + 32'(c));
  endfunction

  hvn_hash u_hash (
    .clk      (clk),
    .rst_n    (rst_n),
    .go       (hgo),
    .px       (hpx),
    .py       (hpy),
    .oct      (oct_r),
    .done     (hdone),
    .hash_val (hval)
  );

  assign hpx = HW'(cx_r + coord_t'(j_r));
  assign hpy = HW'(cy_r + coord_t'(k_r));
  assign x0  = coord_t'(origin_x) + coord_t'(2);
  assign y0  = coord_t'(origin_y) + coord_t'(2);

  always_comb begin
    state_nxt = state_r;
    oct_nxt = oct_r;   cnt_nxt = cnt_r;
    nx_nxt = nx_r;     ny_nxt = ny_r;   nxh_nxt = nxh_r; nyh_nxt = nyh_r;
    cx_nxt = cx_r;     cy_nxt = cy_r;
    cw_nxt = cw_r;     ch_nxt = ch_r;   nw_nxt = nw_r;   nh_nxt = nh_r;
    bw_nxt = bw_r;     bh_nxt = bh_r;
    xoff_nxt = xoff_r; yoff_nxt = yoff_r;
    j_nxt = j_r;       k_nxt = k_r;     dx_nxt = dx_r;   dy_nxt = dy_r;
    acc_nxt = acc_r;   q_nxt = q_r;     tok_nxt = tok_r;
    fr_re = 1'b0; fr_addr = '0; fw_we = 1'b0; fw_addr = '0; fw_data = '0;
    br_re = 1'b0; br_addr = '0; bw_we = 1'b0; bw_addr = '0; bw_data = '0;
    hgo = 1'b0;
    rsp = '0;
    tc = '0; tr = '0; tin = 1'b0;
    ncw = '0; nch = '0;
    hbit = 8'h80 >> oct_r;
    base = '0;
    prod = 25'(acc_r) * 25'(DIV9_MUL);

    unique case (state_r)
      S_IDLE: begin
        if (req.gen_go) begin
          oct_nxt   = '0;
          state_nxt = S_OCT;
        end else if (req.rd_go) begin
          j_nxt     = dim_t'(rd_col) + dim_t'(1);
          k_nxt     = dim_t'(rd_row) + dim_t'(1);
          state_nxt = S_PRD;
        end
      end
      S_OCT: begin
        nx_nxt    = x0;
        ny_nxt    = y0;
        nxh_nxt   = x0 + coord_t'(side_w) + coord_t'(2);
        nyh_nxt   = y0 + coord_t'(side_h) + coord_t'(2);
        cnt_nxt   = 3'(3'(NUM_OCT - 1) - oct_r);
        state_nxt = S_GEOM;
      end
      S_GEOM: begin
        if (cnt_r == '0) begin
          state_nxt = S_SETUP;
        end else begin
          nx_nxt  = lo_shrink(nx_r);
          ny_nxt  = lo_shrink(ny_r);
          nxh_nxt = hi_shrink(nxh_r);
          nyh_nxt = hi_shrink(nyh_r);
          cnt_nxt = cnt_r - 3'd1;
        end
      end
      S_SETUP: begin
        cx_nxt   = lo_shrink(nx_r);
        cy_nxt   = lo_shrink(ny_r);
        ncw      = dim_t'(hi_shrink(nxh_r) - lo_shrink(nx_r));
        nch      = dim_t'(hi_shrink(nyh_r) - lo_shrink(ny_r));
        cw_nxt   = ncw;
        ch_nxt   = nch;
        bw_nxt   = dim_t'({ncw, 1'b0} - 2);
        bh_nxt   = dim_t'({nch, 1'b0} - 2);
        nw_nxt   = dim_t'(nxh_r - nx_r);
        nh_nxt   = dim_t'(nyh_r - ny_r);
        xoff_nxt = nx_r[0] ? (nx_r[SW-1] ? 2'd0 : 2'd2) : 2'd1;
        yoff_nxt = ny_r[0] ? (ny_r[SW-1] ? 2'd0 : 2'd2) : 2'd1;
        j_nxt     = '0;
        k_nxt     = '0;
        state_nxt = S_HRD;
      end
      S_HRD: begin
        tin       = in_fs(j_r, k_r);
        fr_re     = tin;
        fr_addr   = addr_of(j_r, k_r);
        tok_nxt   = tin;
        hgo       = 1'b1;
        state_nxt = S_HWAIT;
      end
      S_HWAIT: begin
        if (hdone) begin
          base    = (oct_r == '0 || !tok_r) ? 8'd0 : fr_q_r;
          fw_we   = in_fs(j_r, k_r);
          fw_addr = addr_of(j_r, k_r);
          fw_data = base + (hval[7:0] & hbit);
          state_nxt = S_HRD;
          if (j_r + dim_t'(1) == cw_r) begin
            j_nxt = '0;
            k_nxt = k_r + dim_t'(1);
            if (k_r + dim_t'(1) == ch_r) begin
              k_nxt     = '0;
              dx_nxt    = '0;
              dy_nxt    = '0;
              state_nxt = S_BTAP;
            end
          end else begin
            j_nxt = j_r + dim_t'(1);
          end
        end
      end
      S_BTAP: begin
        tc      = (j_r + dim_t'(dx_r)) >> 1;
        tr      = (k_r + dim_t'(dy_r)) >> 1;
        tin     = (tc < cw_r) && (tr < ch_r) && in_fs(tc, tr);
        fr_re   = tin;
        fr_addr = addr_of(tc, tr);
        tok_nxt = tin;
        if (dx_r == 2'd0 && dy_r == 2'd0) begin
          acc_nxt = '0;
        end else begin
          acc_nxt = acc_r + (tok_r ? 12'(fr_q_r) : 12'd0);
        end
        if (dx_r == 2'd2) begin
          dx_nxt = '0;
          if (dy_r == 2'd2) begin
            dy_nxt    = '0;
            state_nxt = S_BLAST;
          end else begin
            dy_nxt = dy_r + 2'd1;
          end
        end else begin
          dx_nxt = dx_r + 2'd1;
        end
      end
      S_BLAST: begin
        acc_nxt   = acc_r + (tok_r ? 12'(fr_q_r) : 12'd0);
        state_nxt = S_BDIV;
      end
      S_BDIV: begin
        q_nxt     = prod[DIV9_SH +: 8];
        state_nxt = S_BWR;
      end
      S_BWR: begin
        bw_we   = in_fs(j_r, k_r);
        bw_addr = addr_of(j_r, k_r);
        bw_data = q_r;
        state_nxt = S_BTAP;
        if (j_r + dim_t'(1) == bw_r) begin
          j_nxt = '0;
          k_nxt = k_r + dim_t'(1);
          if (k_r + dim_t'(1) == bh_r) begin
            k_nxt     = '0;
            state_nxt = S_TRD;
          end
        end else begin
          j_nxt = j_r + dim_t'(1);
        end
      end
      S_TRD: begin
        tc        = j_r + dim_t'(xoff_r);
        tr        = k_r + dim_t'(yoff_r);
        tin       = (tc < bw_r) && (tr < bh_r) && in_fs(tc, tr);
        br_re     = tin;
        br_addr   = addr_of(tc, tr);
        tok_nxt   = tin;
        state_nxt = S_TWR;
      end
      S_TWR: begin
        fw_we   = in_fs(j_r, k_r);
        fw_addr = addr_of(j_r, k_r);
        fw_data = tok_r ? br_q_r : 8'd0;
        state_nxt = S_TRD;
        if (j_r + dim_t'(1) == nw_r) begin
          j_nxt = '0;
          k_nxt = k_r + dim_t'(1);
          if (k_r + dim_t'(1) == nh_r) begin
            k_nxt = '0;
            if (oct_r == 3'(NUM_OCT - 1)) begin
              rsp.done   = 1'b1;
              rsp.is_gen = 1'b1;
              state_nxt  = S_IDLE;
            end else begin
              oct_nxt   = oct_r + 3'd1;
              state_nxt = S_OCT;
            end
          end
        end else begin
          j_nxt = j_r + dim_t'(1);
        end
      end
      S_PRD: begin
        tin       = in_fs(j_r, k_r);
        fr_re     = tin;
        fr_addr   = addr_of(j_r, k_r);
        tok_nxt   = tin;
        state_nxt = S_POUT;
      end
      S_POUT: begin
        rsp.done  = 1'b1;
        rsp.pixel = tok_r ? fr_q_r : 8'd0;
        state_nxt = S_IDLE;
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_ff @(posedge clk) begin
    oct_r <= oct_nxt;   cnt_r <= cnt_nxt;
    nx_r <= nx_nxt;     ny_r <= ny_nxt;   nxh_r <= nxh_nxt; nyh_r <= nyh_nxt;
    cx_r <= cx_nxt;     cy_r <= cy_nxt;
    cw_r <= cw_nxt;     ch_r <= ch_nxt;   nw_r <= nw_nxt;   nh_r <= nh_nxt;
    bw_r <= bw_nxt;     bh_r <= bh_nxt;
    xoff_r <= xoff_nxt; yoff_r <= yoff_nxt;
    j_r <= j_nxt;       k_r <= k_nxt;     dx_r <= dx_nxt;   dy_r <= dy_nxt;
    acc_r <= acc_nxt;   q_r <= q_nxt;     tok_r <= tok_nxt;
  end

  always_ff @(posedge clk) begin
    if (fw_we) begin
      front_mem[fw_addr] <= fw_data;
    end
    if (fr_re) begin
      fr_q_r <= front_mem[fr_addr];
    end
  end

  always_ff @(posedge clk) begin
    if (bw_we) begin
      back_mem[bw_addr] <= bw_data;
    end
    if (br_re) begin
      br_q_r <= back_mem[br_addr];
    end
  end

endmodule
`default_nettype wire

@@ src/hashed_value_noise_field_generator_core.sv @@
// Top level: configuration registers, command handshake and result strobe.
// A generate command (cmd 0) builds the noise tile for the configured region
// in seven octaves and then strobes one result with status 0. Its length is
// set by the shared 64-bit hash unit, which runs one shift/add/xor step per
// cycle, and by the 3x3 blur, which reads its nine taps one at a time on the
// single read port of the front field memory. A read command (cmd 1) reads
// the front field memory in the engine's S_PRD and S_POUT states before its
// result strobe is registered; a refused read is answered from a registered
// refuse flag, without going through the engine.
// busy is high from acceptance until the result strobe; the result is shown
// for exactly one cycle and the receiver cannot stall it. The field memories
// need no clearing pass after reset.
`default_nettype none
module hashed_value_noise_field_generator_core #(
  parameter int MAX_SIDE   = 64,
  parameter int FIELD_SIDE = 128
) (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        start,
  output logic             busy,
  input  wire logic        in_cmd,
  input  wire logic [5:0]  in_column,
  input  wire logic [5:0]  in_row,
  output logic             out_strobe,
  output logic [7:0]       out_pixel,
  output logic [1:0]       out_status,
  input  wire logic        cfg_we,
  input  wire logic [1:0]  cfg_index,
  input  wire logic [30:0] cfg_wdata
);
  import hvn_pkg::*;

  logic signed [30:0] origin_x_r, origin_y_r;
  logic [6:0]  width_r, height_r;
  logic        busy_r, ready_r, refuse_r, strobe_r;
  logic [7:0]  pixel_r;
  logic [1:0]  status_r;
  side_t       side_w, side_h;
  logic        accept, refused_now;
  eng_req_t    req;
  eng_rsp_t    rsp;

  function automatic side_t clamp_side(logic [6:0] v);
    side_t s;
    s = v;
    if (v == 7'd0) begin
      s = 7'd1;
    end else if (32'(v) > MAX_SIDE) begin
      s = 7'(MAX_SIDE);
    end
    return s;
  endfunction

  assign side_w      = clamp_side(width_r);
  assign side_h      = clamp_side(height_r);
  assign accept      = start && !busy_r;
  assign refused_now = !ready_r || ({1'b0, in_column} >= side_w)
                       || ({1'b0, in_row} >= side_h);
  assign req.gen_go  = accept && (in_cmd == CMD_GEN);
  assign req.rd_go   = accept && (in_cmd == CMD_READ) && !refused_now;

  hvn_engine #(
    .FIELD_SIDE (FIELD_SIDE)
  ) u_engine (
    .clk      (clk),
    .rst_n    (rst_n),
    .req      (req),
    .origin_x (origin_x_r),
    .origin_y (origin_y_r),
    .side_w   (side_w),
    .side_h   (side_h),
    .rd_col   (in_column),
    .rd_row   (in_row),
    .rsp      (rsp)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      origin_x_r <= '0;
      origin_y_r <= '0;
      width_r    <= 7'd64;
      height_r   <= 7'd64;
      busy_r     <= 1'b0;
      ready_r    <= 1'b0;
      refuse_r   <= 1'b0;
      strobe_r   <= 1'b0;
    end else begin
      strobe_r <= 1'b0;
      if (cfg_we) begin
        unique case (cfg_index)
          REG_ORIGIN_X: origin_x_r <= cfg_wdata;
          REG_ORIGIN_Y: origin_y_r <= cfg_wdata;
          REG_WIDTH:    width_r    <= cfg_wdata[6:0];
          REG_HEIGHT:   height_r   <= cfg_wdata[6:0];
          default:      ;
        endcase
        ready_r <= 1'b0;
      end
      if (accept) begin
        busy_r   <= 1'b1;
        refuse_r <= (in_cmd == CMD_READ) && refused_now;
      end
      if (refuse_r) begin
        refuse_r <= 1'b0;
        busy_r   <= 1'b0;
        strobe_r <= 1'b1;
        pixel_r  <= 8'd0;
        status_r <= ST_REFUSED;
      end else if (rsp.done) begin
        busy_r   <= 1'b0;
        strobe_r <= 1'b1;
        pixel_r  <= rsp.pixel;
        status_r <= rsp.is_gen ? ST_DONE : ST_VALID;
        if (rsp.is_gen) begin
          ready_r <= 1'b1;
        end
      end
    end
  end

  assign busy       = busy_r;
  assign out_strobe = strobe_r;
  assign out_pixel  = pixel_r;
  assign out_status = status_r;

endmodule
`default_nettype wire

@@ src/hvn_checker.sv @@
// Port-level checks for the noise generator core, bound to the top level.
`default_nettype none
module hvn_checker (
  input wire logic       clk,
  input wire logic       rst_n,
  input wire logic       start,
  input wire logic       busy,
  input wire logic       out_strobe,
  input wire logic [7:0] out_pixel,
  input wire logic [1:0] out_status
);
  import hvn_pkg::*;

  a_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
    start && !busy |=> busy)
    else $error("transaction accepted but busy not raised");

  a_strobe_idle: assert property (@(posedge clk) disable iff (!rst_n)
    out_strobe |-> !busy)
    else $error("result strobe while still busy");

  a_no_spurious: assert property (@(posedge clk) disable iff (!rst_n)
    !busy && !start |=> !out_strobe)
    else $error("result without a transaction in flight");

  a_status_code: assert property (@(posedge clk) disable iff (!rst_n)
    out_strobe |-> (out_status == ST_DONE || out_status == ST_VALID
                    || out_status == ST_REFUSED))
    else $error("bad status code");

  a_pixel_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_strobe && out_status != ST_VALID |-> out_pixel == 8'd0)
    else $error("pixel nonzero on non-pixel result");

endmodule

bind hashed_value_noise_field_generator_core hvn_checker u_hvn_checker (.*);
`default_nettype wire

@@ verif/hashed_value_noise_field_generator_core_tb.sv @@
// Self-checking testbench for the hashed value-noise tile generator core.
`timescale 1ns / 1ps
module hashed_value_noise_field_generator_core_tb;
  import hvn_pkg::*;

  localparam int FSIDE = 128;
  localparam int WDOG_LIMIT = 800000;

  typedef struct {
    logic [7:0] pixel;
    logic [1:0] status;
  } pix_rsp_t;

  typedef struct {
    logic       cmd;
    logic [5:0] col;
    logic [5:0] row;
    bit         typed;
    logic [7:0] pixel;
    logic [1:0] status;
  } dir_row_t;

  logic clk, rst_n, start, busy, in_cmd, out_strobe, cfg_we;
  logic [5:0] in_column, in_row;
  logic [7:0] out_pixel;
  logic [1:0] out_status, cfg_index;
  logic [30:0] cfg_wdata;

  logic busy_s, strobe_s;
  logic [7:0] pixel_s;
  logic [1:0] status_s;

  pix_rsp_t rsp_q[$];
  int errors, mismatches, idle_pct, n_items, n_gen, n_read, n_cfg, wdog;

  // shadow state of the block
  logic signed [30:0] sh_ox, sh_oy;
  logic [6:0] sh_w, sh_h;
  bit sh_ready;
  byte unsigned fld_a[FSIDE*FSIDE];
  byte unsigned fld_b[FSIDE*FSIDE];

  hashed_value_noise_field_generator_core dut (
    .clk(clk), .rst_n(rst_n), .start(start), .busy(busy),
    .in_cmd(in_cmd), .in_column(in_column), .in_row(in_row),
    .out_strobe(out_strobe), .out_pixel(out_pixel), .out_status(out_status),
    .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_wdata(cfg_wdata)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  function automatic longint side_of(logic [6:0] v);
    if (v < 1) return 1;
    if (v > 64) return 64;
    return longint'(v);
  endfunction

  function automatic logic [63:0] sra64(logic [63:0] v, int s);
    return $unsigned($signed(v) >>> s);
  endfunction

  function automatic logic [63:0] mix64(logic [63:0] v);
    logic [63:0] a;
    a = v;
    case (v[1:0])
      2'd3: begin
        a += v; a ^= a << 32; a ^= v << 36; a += sra64(a, 22);
      end
      2'd2: begin
        a += v; a ^= a << 22; a += sra64(a, 34);
      end
      2'd1: begin
        a += v; a ^= a << 20; a += sra64(a, 2);
      end
      default: ;
    endcase
    a ^= a << 6;  a += sra64(a, 10);
    a ^= a << 8;  a += sra64(a, 34);
    a ^= a << 50; a += sra64(a, 12);
    return a;
  endfunction

  function automatic logic [63:0] cell_hash(longint px, longint py, longint oc);
    logic [63:0] acc;
    acc = 64'(px);
    acc = mix64(acc);
    acc ^= 64'(py);
    acc = mix64(acc);
    acc ^= 64'(oc);
    return mix64(acc);
  endfunction

  function automatic int fld_get(bit back, longint c, longint r, longint w, longint h);
    if (c < 0 || r < 0 || c >= w || r >= h || c >= FSIDE || r >= FSIDE) return 0;
    return back ? fld_b[r*FSIDE+c] : fld_a[r*FSIDE+c];
  endfunction

  function automatic void fld_set(bit back, longint c, longint r, int v);
    if (c < 0 || r < 0 || c >= FSIDE || r >= FSIDE) return;
    if (back) fld_b[r*FSIDE+c] = v[7:0];
    else fld_a[r*FSIDE+c] = v[7:0];
  endfunction

  function automatic longint shrink_lo(longint v);
    return v / 2 - 1;
  endfunction

  function automatic longint shrink_hi(longint v);
    return 1 - ((-v) / 2);
  endfunction

  function automatic void build_tile();
    longint x0, y0, w, h, nx, ny, nxh, nyh, xoff, yoff, cx, cy, cw, ch, nw, nh, bw, bh;
    int bitv, v, s;
    x0 = longint'(sh_ox) + 2;
    y0 = longint'(sh_oy) + 2;
    w = side_of(sh_w) + 2;
    h = side_of(sh_h) + 2;
    for (int oc = 0; oc < NUM_OCT; oc++) begin
      nx = x0; ny = y0; nxh = x0 + w; nyh = y0 + h;
      bitv = 1 << (7 - oc);
      for (int i = 1; i < NUM_OCT - oc; i++) begin
        nx = shrink_lo(nx); ny = shrink_lo(ny);
        nxh = shrink_hi(nxh); nyh = shrink_hi(nyh);
      end
      xoff = nx - 2 * (nx / 2) + 1;
      yoff = ny - 2 * (ny / 2) + 1;
      cx = shrink_lo(nx);
      cy = shrink_lo(ny);
      cw = shrink_hi(nxh) - cx;
      ch = shrink_hi(nyh) - cy;
      nw = nxh - nx;
      nh = nyh - ny;
      if (oc == 0)
        for (longint k = 0; k < ch; k++)
          for (longint j = 0; j < cw; j++) fld_set(0, j, k, 0);
      for (longint k = 0; k < ch; k++)
        for (longint j = 0; j < cw; j++) begin
          v = fld_get(0, j, k, cw, ch) + int'(cell_hash(cx + j, cy + k, oc) & 64'(bitv));
          fld_set(0, j, k, v);
        end
      bw = 2 * cw - 2;
      bh = 2 * ch - 2;
      for (longint k = 0; k < bh; k++)
        for (longint j = 0; j < bw; j++) begin
          s = 0;
          for (int dy = 0; dy < 3; dy++)
            for (int dx = 0; dx < 3; dx++)
              s += fld_get(0, (j + dx) / 2, (k + dy) / 2, cw, ch);
          fld_set(1, j, k, s / 9);
        end
      for (longint k = 0; k < nh; k++)
        for (longint j = 0; j < nw; j++)
          fld_set(0, j, k, fld_get(1, j + xoff, k + yoff, bw, bh));
    end
    sh_ready = 1;
  endfunction

  function automatic pix_rsp_t predict_pixel(logic cmd, logic [5:0] col, logic [5:0] row);
    pix_rsp_t r;
    r.pixel = 8'd0;
    r.status = ST_DONE;
    if (cmd == CMD_GEN) begin
      build_tile();
    end else if (!sh_ready || col >= side_of(sh_w) || row >= side_of(sh_h)) begin
      r.status = ST_REFUSED;
    end else begin
      r.pixel = 8'(fld_get(0, col + 1, row + 1, side_of(sh_w) + 2, side_of(sh_h) + 2));
      r.status = ST_VALID;
    end
    return r;
  endfunction

  always @(negedge clk) begin
    busy_s   = busy;
    strobe_s = out_strobe;
    pixel_s  = out_pixel;
    status_s = out_status;
    if (rst_n && strobe_s) begin
      if (rsp_q.size() == 0) begin
        errors++;
        mismatches++;
        if (mismatches <= 10) $display("unexpected result pixel=%0d status=%0d", pixel_s, status_s);
      end else begin
        pix_rsp_t e;
        e = rsp_q.pop_front();
        if (e.pixel !== pixel_s || e.status !== status_s) begin
          errors++;
          mismatches++;
          if (mismatches <= 10)
            $display("mismatch: exp pixel=%0d status=%0d, got pixel=%0d status=%0d",
                     e.pixel, e.status, pixel_s, status_s);
        end
      end
    end
  end

  always @(posedge clk) begin
    if (!rst_n || (start && !busy_s) || strobe_s) wdog <= 0;
    else wdog <= wdog + 1;
    if (wdog >= WDOG_LIMIT) begin
      $display("Some tests failed");
      $finish;
    end
  end

  task automatic send_item(logic cmd, logic [5:0] col, logic [5:0] row,
                           bit typed = 0, logic [7:0] tpix = 0, logic [1:0] tst = 0);
    pix_rsp_t p;
    if (idle_pct > 0 && $urandom_range(99) < idle_pct) begin
      start <= 1'b0;
      repeat ($urandom_range(1, 5)) @(posedge clk);
    end
    start <= 1'b1;
    in_cmd <= cmd;
    in_column <= col;
    in_row <= row;
    do @(posedge clk); while (busy_s);
    p = predict_pixel(cmd, col, row);
    if (typed) begin
      p.pixel = tpix;
      p.status = tst;
    end
    rsp_q.push_back(p);
    n_items++;
    if (cmd == CMD_GEN) n_gen++;
    else n_read++;
  endtask

  task automatic drain();
    start <= 1'b0;
    @(posedge clk);
    while (rsp_q.size() != 0) @(posedge clk);
    repeat (8) @(posedge clk);
  endtask

  task automatic cfg_write(reg_idx_t idx, logic [30:0] val);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= val;
    @(posedge clk);
    cfg_we <= 1'b0;
    case (idx)
      REG_ORIGIN_X: sh_ox = val;
      REG_ORIGIN_Y: sh_oy = val;
      REG_WIDTH:    sh_w = val[6:0];
      REG_HEIGHT:   sh_h = val[6:0];
    endcase
    sh_ready = 0;
    n_cfg++;
  endtask

  task automatic cfg_all(logic [30:0] ox, logic [30:0] oy, logic [30:0] w, logic [30:0] h);
    cfg_write(REG_ORIGIN_X, ox);
    cfg_write(REG_ORIGIN_Y, oy);
    cfg_write(REG_WIDTH, w);
    cfg_write(REG_HEIGHT, h);
  endtask

  dir_row_t dir_tab[] = '{
    '{CMD_READ, 6'd0,  6'd0,  1, 8'd0, ST_REFUSED},
    '{CMD_READ, 6'd63, 6'd63, 1, 8'd0, ST_REFUSED},
    '{CMD_GEN,  6'd0,  6'd0,  1, 8'd0, ST_DONE},
    '{CMD_READ, 6'd0,  6'd0,  0, 8'd0, 2'd0},
    '{CMD_READ, 6'd63, 6'd63, 0, 8'd0, 2'd0},
    '{CMD_READ, 6'd63, 6'd0,  0, 8'd0, 2'd0},
    '{CMD_READ, 6'd0,  6'd63, 0, 8'd0, 2'd0},
    '{CMD_READ, 6'd21, 6'd42, 0, 8'd0, 2'd0},
    '{CMD_GEN,  6'd63, 6'd63, 1, 8'd0, ST_DONE},
    '{CMD_READ, 6'd42, 6'd21, 0, 8'd0, 2'd0}
  };

  initial begin
    logic [6:0] w, h;
    rst_n = 1'b0; start = 1'b0; in_cmd = 1'b0; in_column = '0; in_row = '0;
    cfg_we = 1'b0; cfg_index = '0; cfg_wdata = '0;
    busy_s = 1'b0; strobe_s = 1'b0; pixel_s = '0; status_s = '0;
    errors = 0; mismatches = 0; idle_pct = 0; n_items = 0; n_gen = 0; n_read = 0;
    n_cfg = 0; wdog = 0;
    sh_ox = '0; sh_oy = '0; sh_w = 7'd64; sh_h = 7'd64; sh_ready = 0;
    foreach (fld_a[i]) begin
      fld_a[i] = 0;
      fld_b[i] = 0;
    end
    repeat (7) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    foreach (dir_tab[i])
      send_item(dir_tab[i].cmd, dir_tab[i].col, dir_tab[i].row,
                dir_tab[i].typed, dir_tab[i].pixel, dir_tab[i].status);
    drain();

    // zero and oversized sides clamp, origin extremes
    cfg_all(31'h4000_0000, 31'h3FFF_FFFF, 31'd0, 31'd127);
    send_item(CMD_READ, 6'd0, 6'd0, 1, 8'd0, ST_REFUSED);
    send_item(CMD_GEN, 6'd0, 6'd0, 1, 8'd0, ST_DONE);
    send_item(CMD_READ, 6'd0, 6'd0);
    send_item(CMD_READ, 6'd1, 6'd0, 1, 8'd0, ST_REFUSED);
    send_item(CMD_READ, 6'd0, 6'd63);
    drain();
    cfg_all(31'h3FFF_FFFF, 31'h4000_0000, 31'd65, 31'd1);
    send_item(CMD_GEN, 6'd0, 6'd0, 1, 8'd0, ST_DONE);
    send_item(CMD_READ, 6'd63, 6'd0);
    send_item(CMD_READ, 6'd0, 6'd1, 1, 8'd0, ST_REFUSED);
    drain();
    cfg_write(REG_WIDTH, 31'd5);
    send_item(CMD_READ, 6'd0, 6'd0, 1, 8'd0, ST_REFUSED);
    drain();

    for (int ph = 0; ph < 16; ph++) begin
      case (ph % 4)
        0: idle_pct = 0;
        1: idle_pct = 61;
        2: idle_pct = 0;
        default: idle_pct = 20;
      endcase
      if ($urandom_range(3) == 0) begin
        w = 7'($urandom_range(0, 127));
        h = 7'($urandom_range(0, 127));
      end else begin
        w = 7'($urandom_range(1, 10));
        h = 7'($urandom_range(1, 10));
      end
      if (w > 16 || w == 0) w = 7'($urandom_range(0, 1) ? w : 16);
      if (side_of(w) * side_of(h) > 256) h = 7'($urandom_range(1, 4));
      cfg_all(31'($urandom), 31'($urandom), 31'(w), 31'(h));
      repeat ($urandom_range(0, 2)) send_item(CMD_READ, 6'($urandom), 6'($urandom));
      send_item(CMD_GEN, 6'($urandom), 6'($urandom));
      for (int n = 0; n < 85; n++) begin
        if ($urandom_range(19) == 0)
          send_item(CMD_GEN, 6'($urandom), 6'($urandom));
        else if ($urandom_range(4) == 0)
          send_item(CMD_READ, 6'($urandom), 6'($urandom));
        else
          send_item(CMD_READ, 6'($urandom_range(0, 32'(side_of(w)))),
                    6'($urandom_range(0, 32'(side_of(h)))));
      end
      drain();
    end

    $display("Covered %0d transactions (%0d generate, %0d read) and %0d register writes,",
             n_items, n_gen, n_read, n_cfg);
    $display("including clamped sides, origin extremes and refused reads.");
    if (errors == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

endmodule

@@ filelist.f @@
src/hvn_pkg.sv
src/hvn_hash.sv
src/hvn_engine.sv
src/hashed_value_noise_field_generator_core.sv
src/hvn_checker.sv
verif/hashed_value_noise_field_generator_core_tb.sv
